// ----- hw/rtl/gmc_pkg.sv -----
`default_nettype none

package gmc_pkg;

   // Field widths that the interface fixes.
   localparam int DIM_W  = 6;
   localparam int CELL_W = 10;
   localparam int REM_W  = 11;
   localparam int RAND_W = 16;

   // Reset sizes of the grid.
   localparam logic [DIM_W-1:0] GRID_WIDTH_RESET  = 6'd32;
   localparam logic [DIM_W-1:0] GRID_HEIGHT_RESET = 6'd32;

   // Register indexes, taken from the word address of the register port.
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // Wall directions; the opposite wall is the direction with bit 1 flipped.
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   typedef struct packed {
      logic              restart;
      logic [RAND_W-1:0] rand_value;
   } gmc_req_type;

   typedef struct packed {
      logic [CELL_W-1:0] from_cell;
      logic [1:0]        direction;
      logic [CELL_W-1:0] to_cell;
      logic              last;
   } gmc_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_COLFIX,
      ST_GATHER,
      ST_CHOOSE,
      ST_HUNT_STEP,
      ST_HUNT_CHECK,
      ST_CARVE_FROM,
      ST_CARVE_TO
   } gmc_state_type;

   // Passage bit of one wall: bit 0 up, bit 1 right, bit 2 down, bit 3 left.
   function automatic logic [3:0] wall_bit(input logic [1:0] dir);
      logic [3:0] bits;
      case (dir)
         DIR_UP:    bits = 4'b0001;
         DIR_RIGHT: bits = 4'b0010;
         DIR_DOWN:  bits = 4'b0100;
         default:   bits = 4'b1000;
      endcase
      return bits;
   endfunction

   // Remainder by three: base-four digits sum to the same residue, folded twice.
   function automatic logic [1:0] mod3_16(input logic [RAND_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = '0;
      for (int i = 0; i < RAND_W / 2; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/grid_maze_carver.sv -----
// Carve item, when the cursor has an unvisited neighbour: start, a scan of the own cell and
// its four neighbours through the single cell store read port, choice, two writes.
// Each hunted cell adds a hunt step and a hunt check, and each rescan a new scan and choice.
// A restart item sweeps the whole cell store and yields no result.
// After reset the same clearing sweep runs with req_stall high; configuration is taken.
// One item is in work at a time; a waiting result holds the next item at its far-wall write.
`default_nettype none

module grid_maze_carver #(
   parameter int MAX_WIDTH  = 32,
   parameter int MAX_HEIGHT = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  gmc_pkg::gmc_req_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output gmc_pkg::gmc_rsp_type  rsp_data,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire  [2:0]            csr_paddr,
   input  wire  [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
   localparam int IdxW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);
   localparam int HuntW = $clog2(Depth + 2);
   localparam int SumW  = CntW + 1;
   localparam int DimW  = gmc_pkg::DIM_W;
   localparam int RemW  = gmc_pkg::REM_W;
   localparam int CellW = gmc_pkg::CELL_W;
   localparam int RandW = gmc_pkg::RAND_W;

   gmc_pkg::gmc_state_type state_ff, state_in;

   logic [DimW-1:0]  grid_width_ff, grid_width_in;
   logic [DimW-1:0]  grid_height_ff, grid_height_in;
   logic [DimW-1:0]  w_used_ff, w_used_in;
   logic [DimW-1:0]  h_used_in;
   logic [CntW-1:0]  cells_ff, cells_in;

   logic [IdxW-1:0]  clr_addr_ff, clr_addr_in;
   logic             restart_ff, restart_in;
   logic [RandW-1:0] rand_ff, rand_in;
   logic [IdxW-1:0]  cursor_ff, cursor_in;
   logic [DimW-1:0]  col_ff, col_in;
   logic             col_ok_ff, col_ok_in;
   logic [IdxW-1:0]  rem_ff, rem_in;
   logic [RemW-1:0]  remaining_ff, remaining_in;
   logic [HuntW-1:0] hunts_ff, hunts_in;
   logic [2:0]       gstep_ff, gstep_in;
   logic             pend_ok_ff, pend_ok_in;
   logic [3:0]       mask_ff, mask_in;
   logic [3:0]       own_ff, own_in;
   logic [1:0]       dir_ff, dir_in;
   logic [IdxW-1:0]  to_ff, to_in;
   logic             rsp_valid_ff, rsp_valid_in;
   gmc_pkg::gmc_rsp_type rsp_data_ff, rsp_data_in;

   // Cell store.
   logic [3:0]       store_mem [Depth];
   logic [3:0]       rdata_ff;
   logic             mem_we;
   logic [IdxW-1:0]  mem_waddr;
   logic [3:0]       mem_wdata;
   logic [IdxW-1:0]  mem_raddr;

   // Shared neighbour address unit.
   logic [1:0]       nb_dir;
   logic [SumW-1:0]  nb_cur, nb_off, nb_sum;
   logic             nb_ok;
   logic [IdxW-1:0]  nb_addr;

   logic [2:0]       pick_count;
   logic [1:0]       pick_rank;
   logic [1:0]       pick_dir;
   logic [CntW-1:0]  hunt_sum;
   logic             hunt_wrap;
   logic             csr_write;
   logic             out_free;
   logic             out_load;

   // Register port: writes on the access phase, reads combinational.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         gmc_pkg::REG_GRID_WIDTH:  csr_prdata = 32'(grid_width_ff);
         gmc_pkg::REG_GRID_HEIGHT: csr_prdata = 32'(grid_height_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // Grid size in use, clamped to one and to the store's maximum.
   always_comb begin
      if (grid_width_ff == '0) begin
         w_used_in = DimW'(1);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         w_used_in = DimW'(MAX_WIDTH);
      end else begin
         w_used_in = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         h_used_in = DimW'(1);
      end else if (32'(grid_height_ff) > MAX_HEIGHT) begin
         h_used_in = DimW'(MAX_HEIGHT);
      end else begin
         h_used_in = grid_height_ff;
      end
      cells_in = CntW'((2 * DimW)'(w_used_in) * (2 * DimW)'(h_used_in));
   end

   // Neighbour address and bounds check for the selected direction.
   always_comb begin
      nb_cur = SumW'(cursor_ff);
      if (nb_dir == gmc_pkg::DIR_UP || nb_dir == gmc_pkg::DIR_DOWN) begin
         nb_off = SumW'(w_used_ff);
      end else begin
         nb_off = SumW'(1'b1);
      end
      if (nb_dir == gmc_pkg::DIR_UP || nb_dir == gmc_pkg::DIR_LEFT) begin
         nb_sum = nb_cur - nb_off;
      end else begin
         nb_sum = nb_cur + nb_off;
      end
      case (nb_dir)
         gmc_pkg::DIR_UP:    nb_ok = (nb_cur >= nb_off);
         gmc_pkg::DIR_RIGHT: nb_ok = (nb_sum < SumW'(cells_ff)) &&
                                     (({1'b0, col_ff} + 1'b1) != {1'b0, w_used_ff});
         gmc_pkg::DIR_DOWN:  nb_ok = (nb_sum < SumW'(cells_ff));
         default:            nb_ok = (col_ff != '0);
      endcase
      nb_addr = IdxW'(nb_sum);
   end

   // Choice among the unvisited neighbours: rank is the random word modulo their count.
   always_comb begin
      logic [1:0] seen;
      logic       found;
      pick_count = 3'(mask_ff[0]) + 3'(mask_ff[1]) + 3'(mask_ff[2]) + 3'(mask_ff[3]);
      case (pick_count)
         3'd2:    pick_rank = {1'b0, rand_ff[0]};
         3'd3:    pick_rank = gmc_pkg::mod3_16(rand_ff);
         3'd4:    pick_rank = rand_ff[1:0];
         default: pick_rank = 2'd0;
      endcase
      seen     = 2'd0;
      found    = 1'b0;
      pick_dir = gmc_pkg::DIR_UP;
      for (int d = 0; d < 4; d++) begin
         if (mask_ff[d] && !found) begin
            if (seen == pick_rank) begin
               pick_dir = 2'(d);
               found    = 1'b1;
            end
            seen = seen + 2'd1;
         end
      end
   end

   // Hunt walks forward through the raster with wraparound.
   assign hunt_sum  = CntW'(cursor_ff) + 1'b1;
   assign hunt_wrap = (hunt_sum >= cells_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == gmc_pkg::ST_CARVE_TO) && out_free;

   assign req_stall = (state_ff != gmc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: next state, datapath registers and store access.
   always_comb begin
      state_in       = state_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      clr_addr_in    = clr_addr_ff;
      restart_in     = restart_ff;
      rand_in        = rand_ff;
      cursor_in      = cursor_ff;
      col_in         = col_ff;
      col_ok_in      = col_ok_ff;
      rem_in         = rem_ff;
      remaining_in   = remaining_ff;
      hunts_in       = hunts_ff;
      gstep_in       = gstep_ff;
      pend_ok_in     = pend_ok_ff;
      mask_in        = mask_ff;
      own_in         = own_ff;
      dir_in         = dir_ff;
      to_in          = to_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      mem_we         = 1'b0;
      mem_waddr      = cursor_ff;
      mem_wdata      = '0;
      mem_raddr      = cursor_ff;
      nb_dir         = 2'(gstep_ff - 3'd1);

      unique case (state_ff)
         gmc_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == IdxW'(Depth - 1)) begin
               state_in = gmc_pkg::ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         gmc_pkg::ST_IDLE: begin
            if (req_valid) begin
               restart_in = req_data.restart;
               rand_in    = req_data.rand_value;
               state_in   = gmc_pkg::ST_START;
            end
         end

         gmc_pkg::ST_START: begin
            hunts_in = '0;
            gstep_in = '0;
            mask_in  = '0;
            if (restart_ff) begin
               cursor_in    = '0;
               col_in       = '0;
               col_ok_in    = 1'b1;
               remaining_in = RemW'(cells_ff - 1'b1);
               clr_addr_in  = '0;
               state_in     = gmc_pkg::ST_CLEAR;
            end else if (remaining_ff == '0) begin
               state_in = gmc_pkg::ST_IDLE;
            end else if (CntW'(cursor_ff) >= cells_ff) begin
               cursor_in = '0;
               col_in    = '0;
               col_ok_in = 1'b1;
               state_in  = gmc_pkg::ST_GATHER;
            end else if (!col_ok_ff) begin
               rem_in   = cursor_ff;
               state_in = gmc_pkg::ST_COLFIX;
            end else begin
               state_in = gmc_pkg::ST_GATHER;
            end
         end

         // Column of the cursor by repeated subtraction after a size change.
         gmc_pkg::ST_COLFIX: begin
            if (CntW'(rem_ff) >= CntW'(w_used_ff)) begin
               rem_in = rem_ff - IdxW'(w_used_ff);
            end else begin
               col_in    = DimW'(rem_ff);
               col_ok_in = 1'b1;
               state_in  = gmc_pkg::ST_GATHER;
            end
         end

         // Own cell, then up, right, down, left; each registered read is checked in the next cycle.
         gmc_pkg::ST_GATHER: begin
            if (gstep_ff == 3'd0) begin
               mem_raddr  = cursor_ff;
               pend_ok_in = 1'b1;
            end else begin
               mem_raddr  = nb_addr;
               pend_ok_in = nb_ok;
            end
            if (gstep_ff == 3'd1) begin
               own_in = rdata_ff;
            end else if (gstep_ff != 3'd0) begin
               if (pend_ok_ff && rdata_ff == '0) begin
                  mask_in[2'(gstep_ff - 3'd2)] = 1'b1;
               end
            end
            if (gstep_ff == 3'd5) begin
               state_in = gmc_pkg::ST_CHOOSE;
            end else begin
               gstep_in = gstep_ff + 3'd1;
            end
         end

         gmc_pkg::ST_CHOOSE: begin
            nb_dir = pick_dir;
            if (mask_ff == '0) begin
               state_in = gmc_pkg::ST_HUNT_STEP;
            end else begin
               dir_in   = pick_dir;
               to_in    = nb_addr;
               state_in = gmc_pkg::ST_CARVE_FROM;
            end
         end

         gmc_pkg::ST_HUNT_STEP: begin
            hunts_in = hunts_ff + 1'b1;
            if (hunt_wrap) begin
               cursor_in = '0;
               col_in    = '0;
            end else begin
               cursor_in = IdxW'(hunt_sum);
               if (({1'b0, col_ff} + 1'b1) == {1'b0, w_used_ff}) begin
                  col_in = '0;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            mem_raddr = cursor_in;
            state_in  = gmc_pkg::ST_HUNT_CHECK;
         end

         gmc_pkg::ST_HUNT_CHECK: begin
            gstep_in = '0;
            mask_in  = '0;
            if (HuntW'(hunts_ff) > HuntW'(cells_ff)) begin
               remaining_in = '0;
               state_in     = gmc_pkg::ST_IDLE;
            end else if (rdata_ff == '0) begin
               state_in = gmc_pkg::ST_HUNT_STEP;
            end else begin
               state_in = gmc_pkg::ST_GATHER;
            end
         end

         gmc_pkg::ST_CARVE_FROM: begin
            mem_we    = 1'b1;
            mem_waddr = cursor_ff;
            mem_wdata = own_ff | gmc_pkg::wall_bit(dir_ff);
            state_in  = gmc_pkg::ST_CARVE_TO;
         end

         // Open the far wall and hand out the beat once the output register is free.
         gmc_pkg::ST_CARVE_TO: begin
            if (out_free) begin
               mem_we                = 1'b1;
               mem_waddr             = to_ff;
               mem_wdata             = gmc_pkg::wall_bit(dir_ff ^ 2'b10);
               rsp_valid_in          = 1'b1;
               rsp_data_in.from_cell = CellW'(cursor_ff);
               rsp_data_in.direction = dir_ff;
               rsp_data_in.to_cell   = CellW'(to_ff);
               rsp_data_in.last      = (remaining_ff == RemW'(1));
               remaining_in          = remaining_ff - 1'b1;
               cursor_in             = to_ff;
               case (dir_ff)
                  gmc_pkg::DIR_RIGHT: col_in = col_ff + 1'b1;
                  gmc_pkg::DIR_LEFT:  col_in = col_ff - 1'b1;
                  default:            col_in = col_ff;
               endcase
               state_in = gmc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gmc_pkg::ST_IDLE;
         end
      endcase

      // Configuration writes; any write, of width or height, invalidates the cursor's column.
      if (csr_write) begin
         unique case (csr_paddr[2])
            gmc_pkg::REG_GRID_WIDTH:  grid_width_in  = csr_pwdata[DimW-1:0];
            gmc_pkg::REG_GRID_HEIGHT: grid_height_in = csr_pwdata[DimW-1:0];
            default:                  grid_width_in  = grid_width_ff;
         endcase
         col_ok_in = 1'b0;
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= gmc_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= gmc_pkg::GRID_HEIGHT_RESET;
         clr_addr_ff    <= '0;
         cursor_ff      <= '0;
         col_ff         <= '0;
         col_ok_ff      <= 1'b1;
         remaining_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         clr_addr_ff    <= clr_addr_in;
         cursor_ff      <= cursor_in;
         col_ff         <= col_in;
         col_ok_ff      <= col_ok_in;
         remaining_ff   <= remaining_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      w_used_ff   <= w_used_in;
      cells_ff    <= cells_in;
      restart_ff  <= restart_in;
      rand_ff     <= rand_in;
      rem_ff      <= rem_in;
      hunts_ff    <= hunts_in;
      gstep_ff    <= gstep_in;
      pend_ok_ff  <= pend_ok_in;
      mask_ff     <= mask_in;
      own_ff      <= own_in;
      dir_ff      <= dir_in;
      to_ff       <= to_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Cell store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= store_mem[mem_raddr];
   end

   // A new result only ever comes from the far-wall write.
   a_rsp_from_carve: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == gmc_pkg::ST_CARVE_TO)
      else $error("result raised outside the carve step");

   // The chosen direction is always one of the unvisited neighbours found.
   a_dir_unvisited: assert property (@(posedge clock) disable iff (reset)
      state_ff == gmc_pkg::ST_CARVE_FROM |-> mask_ff[dir_ff])
      else $error("carving towards a visited or absent neighbour");

   // No carve is started with the count exhausted.
   a_carve_counted: assert property (@(posedge clock) disable iff (reset)
      state_ff == gmc_pkg::ST_CARVE_FROM |-> remaining_ff != '0)
      else $error("carve started with no visits remaining");

   // Each result takes exactly one visit off the count.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      out_load |=> remaining_ff == RemW'($past(remaining_ff) - 1'b1))
      else $error("remaining count not decremented by one");

   // A hunt check always follows a hunt step.
   a_hunt_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == gmc_pkg::ST_HUNT_CHECK |-> $past(state_ff) == gmc_pkg::ST_HUNT_STEP)
      else $error("hunt check without a hunt step");

endmodule

`default_nettype wire
